### hdl/wpc_pkg.sv
// Types, constants and helpers shared by the waypoint PD position controller.
// No dependencies; compile first.
package wpc_pkg;

  typedef logic signed [15:0] pos_t;   // Q7.8 metres
  typedef logic signed [16:0] err_t;   // position error, exact
  typedef logic signed [17:0] diff_t;  // error change, exact
  typedef logic signed [34:0] sum_t;   // gain products, 20 fraction bits
  typedef logic signed [29:0] q_t;     // scaled to Q1.14, before clamp
  typedef logic signed [15:0] cmd_t;   // Q1.14 radians
  typedef logic [15:0]        gain_t;  // unsigned Q4.12
  typedef logic [14:0]        lim_t;   // 15-bit unsigned magnitudes
  typedef logic [1:0]         wp_t;

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_DERIV_GAIN    = 3'd1,
    REG_ARRIVE_THRESH = 3'd2,
    REG_FAR_DISTANCE  = 3'd3,
    REG_NARROW_LIMIT  = 3'd4,
    REG_WIDE_LIMIT    = 3'd5,
    REG_PITCH_TRIM    = 3'd6
  } wpc_reg_t;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam gain_t RST_PROP_GAIN     = 16'd410;
  localparam gain_t RST_DERIV_GAIN    = 16'd16384;
  localparam lim_t  RST_ARRIVE_THRESH = 15'd26;
  localparam lim_t  RST_FAR_DISTANCE  = 15'd128;
  localparam lim_t  RST_NARROW_LIMIT  = 15'd1475;
  localparam lim_t  RST_WIDE_LIMIT    = 15'd2458;
  localparam cmd_t  RST_PITCH_TRIM    = 16'sd82;

  // waypoint loop, Q7.8 metres
  localparam pos_t WP_X [4] = '{16'sd768, 16'sd2048, 16'sd2048, 16'sd768};
  localparam pos_t WP_Y [4] = '{16'sd384, 16'sd384, 16'sd768, 16'sd768};

  // pipeline advance controls handed to each lane
  typedef struct packed {
    logic acc;  // word accepted, state and stage 1 load
    logic en2;  // product stage loads
    logic en3;  // scaled result stage loads
  } wpc_adv_t;

  // symmetric clamp; magnitude at or above the limit takes the limit
  function automatic cmd_t clamp_sym(q_t v, lim_t lim);
    q_t lim_s;
    lim_s = q_t'({1'b0, lim});
    if (v >= lim_s) begin
      return cmd_t'(lim_s);
    end else if (v <= -lim_s) begin
      return cmd_t'(-lim_s);
    end else begin
      return cmd_t'(v);
    end
  endfunction

endpackage

### hdl/wpc_if.sv
// Valid/ready channel interfaces for measured positions and commands.
// Depends on wpc_pkg.
interface wpc_meas_if;
  import wpc_pkg::*;
  logic valid;
  logic ready;
  pos_t meas_x;
  pos_t meas_y;
  modport source (output valid, output meas_x, output meas_y, input ready);
  modport sink (input valid, input meas_x, input meas_y, output ready);
endinterface

interface wpc_cmd_if;
  import wpc_pkg::*;
  logic valid;
  logic ready;
  cmd_t roll_cmd;
  cmd_t pitch_cmd;
  wp_t  waypoint_now;
  logic arrived;
  modport source (output valid, output roll_cmd, output pitch_cmd,
                  output waypoint_now, output arrived, input ready);
  modport sink (input valid, input roll_cmd, input pitch_cmd,
                input waypoint_now, input arrived, output ready);
endinterface

### hdl/wpc_lane.sv
// One axis of the PD law: error, held previous error, gain products,
// rounding to Q1.14 and trim. Depends on wpc_pkg.
module wpc_lane (
  input  logic              clk,
  input  logic              rst,
  input  wpc_pkg::wpc_adv_t adv,
  input  wpc_pkg::pos_t     meas,
  input  wpc_pkg::pos_t     target,
  input  wpc_pkg::gain_t    kp,
  input  wpc_pkg::gain_t    kd,
  input  wpc_pkg::cmd_t     trim,
  output wpc_pkg::err_t     err,
  output wpc_pkg::q_t       q
);
  import wpc_pkg::*;

  err_t  prev_err;
  err_t  e1;
  diff_t d1;
  sum_t  p2;
  sum_t  dd2;
  sum_t  s;
  sum_t  s_rnd;
  q_t    q3;

  assign err = err_t'(target) - err_t'(meas);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
    end else if (adv.acc) begin
      prev_err <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.acc) begin
      e1 <= err;
      d1 <= diff_t'(err) - diff_t'(prev_err);
    end
    if (adv.en2) begin
      p2  <= sum_t'($signed({1'b0, kp})) * sum_t'(e1);
      dd2 <= sum_t'($signed({1'b0, kd})) * sum_t'(d1);
    end
    if (adv.en3) begin
      q3 <= q_t'(s_rnd >>> 6) - q_t'(trim);
    end
  end

  // round half up: floor((s + 32) / 64)
  assign s     = p2 + dd2;
  assign s_rnd = s + sum_t'(32);
  assign q     = q3;

endmodule

### hdl/wpc_merge.sv
// Merge stage: picks the shared limit, clamps both lanes and holds the
// command word in the output register. Depends on wpc_pkg, wpc_if.
module wpc_merge (
  input  logic           clk,
  input  logic           rst,
  input  logic           lane_valid,
  input  wpc_pkg::q_t    q_pitch,
  input  wpc_pkg::q_t    q_roll,
  input  logic           far,
  input  wpc_pkg::wp_t   wp,
  input  logic           arr,
  input  wpc_pkg::lim_t  narrow_limit,
  input  wpc_pkg::lim_t  wide_limit,
  output logic           en_out,
  wpc_cmd_if.source      cmd
);
  import wpc_pkg::*;

  lim_t lim;

  assign lim    = far ? narrow_limit : wide_limit;
  assign en_out = !cmd.valid || cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (en_out) begin
      cmd.valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && lane_valid) begin
      cmd.pitch_cmd    <= clamp_sym(q_pitch, lim);
      cmd.roll_cmd     <= clamp_sym(q_roll, lim);
      cmd.waypoint_now <= wp;
      cmd.arrived      <= arr;
    end
  end

endmodule

### hdl/waypoint_pd_position_controller.sv
// Top level of the two-axis waypoint PD position controller.
// Depends on wpc_pkg, wpc_if, wpc_lane and wpc_merge.
//
// Takes one measured position word per clock while the output is not
// stalled and returns one command word for each from the output register.
// The x lane drives pitch (less the trim) and the y lane drives roll; the
// merge stage clamps both to the narrow limit when either signed error is
// beyond far_distance, else to the wide limit. Errors, arrival and the
// waypoint index are settled in the cycle a word is accepted, so the held
// state is ready for the next word on the following clock and the block
// sustains one word per cycle unless the output stalls; gain products and
// rounding follow in two further stages. A waiting output word does not
// stop acceptance while the pipeline has an empty stage. The user
// must write cfg_* registers only while the block is idle (not enforced).
module waypoint_pd_position_controller #(
  parameter int unsigned NUM_WAYPOINTS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [wpc_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [wpc_pkg::CfgDataW-1:0]    cfg_data,
  wpc_meas_if.sink                        meas,
  wpc_cmd_if.source                       cmd
);
  import wpc_pkg::*;

  localparam int unsigned IdxW = (NUM_WAYPOINTS > 2) ? $clog2(NUM_WAYPOINTS) : 1;

  gain_t prop_gain;
  gain_t deriv_gain;
  lim_t  arrive_thresh;
  lim_t  far_distance;
  lim_t  narrow_limit;
  lim_t  wide_limit;
  cmd_t  pitch_trim;

  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] idx_next;
  logic [IdxW+1:0] idx_ext;
  pos_t            target_x;
  pos_t            target_y;

  err_t     err_x;
  err_t     err_y;
  err_t     abs_x;
  err_t     abs_y;
  err_t     far_s;
  logic     arr_now;
  logic     far_now;
  q_t       q_pitch;
  q_t       q_roll;

  logic     v1, v2, v3;
  logic     far1, far2, far3;
  logic     arr1, arr2, arr3;
  wp_t      wp1, wp2, wp3;
  logic     en_out, en1, en2, en3, acc;
  wpc_adv_t adv;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= RST_PROP_GAIN;
      deriv_gain    <= RST_DERIV_GAIN;
      arrive_thresh <= RST_ARRIVE_THRESH;
      far_distance  <= RST_FAR_DISTANCE;
      narrow_limit  <= RST_NARROW_LIMIT;
      wide_limit    <= RST_WIDE_LIMIT;
      pitch_trim    <= RST_PITCH_TRIM;
    end else if (cfg_wr_en) begin
      case (wpc_reg_t'(cfg_index))
        REG_PROP_GAIN:     prop_gain     <= cfg_data;
        REG_DERIV_GAIN:    deriv_gain    <= cfg_data;
        REG_ARRIVE_THRESH: arrive_thresh <= cfg_data[14:0];
        REG_FAR_DISTANCE:  far_distance  <= cfg_data[14:0];
        REG_NARROW_LIMIT:  narrow_limit  <= cfg_data[14:0];
        REG_WIDE_LIMIT:    wide_limit    <= cfg_data[14:0];
        REG_PITCH_TRIM:    pitch_trim    <= cmd_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // stage advance, back to front
  assign en3 = !v3 || en_out;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign acc = meas.valid && en1;
  assign meas.ready = en1;

  assign adv.acc = acc;
  assign adv.en2 = en2;
  assign adv.en3 = en3;

  wpc_lane u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .meas   (meas.meas_x),
    .target (target_x),
    .kp     (prop_gain),
    .kd     (deriv_gain),
    .trim   (pitch_trim),
    .err    (err_x),
    .q      (q_pitch)
  );

  wpc_lane u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .meas   (meas.meas_y),
    .target (target_y),
    .kp     (prop_gain),
    .kd     (deriv_gain),
    .trim   ('0),
    .err    (err_y),
    .q      (q_roll)
  );

  // far and arrival tests against the held target
  assign far_s   = err_t'({2'b00, far_distance});
  assign far_now = (err_x > far_s) || (err_y > far_s);
  assign abs_x   = err_x[16] ? -err_x : err_x;
  assign abs_y   = err_y[16] ? -err_y : err_y;
  assign arr_now = (abs_x < {2'b00, arrive_thresh}) && (abs_y < {2'b00, arrive_thresh});

  always_comb begin
    idx_next = idx;
    if (arr_now) begin
      idx_next = (idx == IdxW'(NUM_WAYPOINTS - 1)) ? '0 : idx + 1'b1;
    end
  end
  assign idx_ext = (IdxW + 2)'(idx_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      target_x <= '0;
      target_y <= '0;
    end else if (acc) begin
      idx      <= idx_next;
      target_x <= WP_X[idx_ext[1:0]];
      target_y <= WP_Y[idx_ext[1:0]];
    end
  end

  // sideband travelling beside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= acc;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      far1 <= far_now;
      arr1 <= arr_now;
      wp1  <= idx_ext[1:0];
    end
    if (en2) begin
      far2 <= far1;
      arr2 <= arr1;
      wp2  <= wp1;
    end
    if (en3) begin
      far3 <= far2;
      arr3 <= arr2;
      wp3  <= wp2;
    end
  end

  wpc_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .lane_valid   (v3),
    .q_pitch      (q_pitch),
    .q_roll       (q_roll),
    .far          (far3),
    .wp           (wp3),
    .arr          (arr3),
    .narrow_limit (narrow_limit),
    .wide_limit   (wide_limit),
    .en_out       (en_out),
    .cmd          (cmd)
  );

`ifndef SYNTHESIS
  // index stays within the loop
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= IdxW'(NUM_WAYPOINTS - 1))
    else $error("waypoint index out of range");

  // index moves only on an accepted word that arrived
  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    !(acc && arr_now) |=> $stable(idx))
    else $error("waypoint index moved without arrival");

  // a stalled lane result holds until the merge stage takes it
  a_lane_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !en3) |=> (v3 && $stable(q_pitch) && $stable(q_roll)))
    else $error("lane result changed while stalled");
`endif

endmodule

### tb/sv/waypoint_pd_position_controller_test.sv
`timescale 1ns / 100ps
// Self-checking bench for waypoint_pd_position_controller: a directed probe table, then
// random position words over several register settings and handshake patterns.
// Depends on wpc_pkg, wpc_if and the controller RTL.
module waypoint_pd_position_controller_test;
  import wpc_pkg::*;

  localparam int NUM_WP          = 4;
  localparam int NUM_PHASES      = 8;
  localparam int WORDS_PER_PHASE = 235;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_CYCLES     = 150;
  localparam int SETTLE_CYCLES   = 6;
  localparam int TAIL_CYCLES     = 10;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_REPORTS     = 60;

  localparam logic [CfgIndexW-1:0] REG_SPARE_IDX = 3'd7;  // not decoded

  typedef struct packed {
    cmd_t roll;
    cmd_t pitch;
    wp_t  wp;
    logic arrived;
  } cmd_word_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
    logic typed;  // expected word given below, else predicted
    cmd_t roll;
    cmd_t pitch;
    wp_t  wp;
    logic arrived;
  } probe_row_t;

  localparam int NUM_PROBES = 18;
  localparam probe_row_t PROBES [NUM_PROBES] = '{
    // origin straight after reset counts as arrival at the held (0,0) target
    '{16'sd0, 16'sd0, 1'b1, 16'sd0, -16'sd82, 2'd1, 1'b1},
    // large negative errors are never far: wide limit, both saturate low
    '{16'sd32767, 16'sd32767, 1'b1, -16'sd2458, -16'sd2458, 2'd1, 1'b0},
    // large positive errors: narrow limit, both saturate high
    '{16'sh8000, 16'sh8000, 1'b1, 16'sd1475, 16'sd1475, 2'd1, 1'b0},
    // walk the whole waypoint loop, wrapping back to index 1
    '{16'sd2048, 16'sd384, 1'b0, '0, '0, '0, 1'b0},
    '{16'sd2048, 16'sd768, 1'b0, '0, '0, '0, 1'b0},
    '{16'sd768, 16'sd768, 1'b0, '0, '0, '0, 1'b0},
    '{16'sd768, 16'sd384, 1'b0, '0, '0, '0, 1'b0},
    // arrival is strict: error of exactly the threshold does not count, one less does
    '{16'sd2022, 16'sd384, 1'b0, '0, '0, '0, 1'b0},
    '{16'sd2048, 16'sd409, 1'b0, '0, '0, '0, 1'b0},
    // far test is strict, on either axis
    '{16'sd1920, 16'sd768, 1'b0, '0, '0, '0, 1'b0},
    '{16'sd1919, 16'sd768, 1'b0, '0, '0, '0, 1'b0},
    '{16'sd2048, 16'sd639, 1'b0, '0, '0, '0, 1'b0},
    '{16'sd4048, 16'sd768, 1'b0, '0, '0, '0, 1'b0},
    '{16'sd2048, 16'sd768, 1'b0, '0, '0, '0, 1'b0},
    '{16'sh5555, 16'shAAAA, 1'b0, '0, '0, '0, 1'b0},
    '{16'shAAAA, 16'sh5555, 1'b0, '0, '0, '0, 1'b0},
    '{-16'sd1, 16'sd1, 1'b0, '0, '0, '0, 1'b0},
    '{16'sd1, -16'sd1, 1'b0, '0, '0, '0, 1'b0}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  wpc_meas_if meas_ch ();
  wpc_cmd_if  cmd_ch ();

  waypoint_pd_position_controller #(
    .NUM_WAYPOINTS (NUM_WP)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .meas      (meas_ch),
    .cmd       (cmd_ch)
  );

  // controller model: registers and held state
  gain_t       kp         = RST_PROP_GAIN;
  gain_t       kd         = RST_DERIV_GAIN;
  lim_t        thresh     = RST_ARRIVE_THRESH;
  lim_t        far_dist   = RST_FAR_DISTANCE;
  lim_t        lim_narrow = RST_NARROW_LIMIT;
  lim_t        lim_wide   = RST_WIDE_LIMIT;
  cmd_t        trim       = RST_PITCH_TRIM;
  err_t        prev_ex    = '0;
  err_t        prev_ey    = '0;
  pos_t        tgt_x      = '0;
  pos_t        tgt_y      = '0;
  int unsigned wp_idx     = 0;

  cmd_word_t pending_cmds [$];

  int errors        = 0;
  int words_sent    = 0;
  int cmds_checked  = 0;
  int advances      = 0;
  int narrow_hits   = 0;
  int settings_used = 1;
  int cycle_count   = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_toggle    = 1'b0;
  bit hold_seen      = 1'b0;
  int hold_left      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d command words outstanding", $time,
               pending_cmds.size());
      $display("FAILURE");
      $finish;
    end
  end

  // gain products at 20 fraction bits, rounded half up to Q1.14
  function automatic longint scaled_pd(int e, int p);
    longint s;
    longint q;
    s = longint'(kp) * e + longint'(kd) * (longint'(e) - p);
    q = (s + 32) >>> 6;
    if (q > 64'sh3FFF_FFFF) q = 64'sh3FFF_FFFF;
    if (q < -64'sh3FFF_FFFF) q = -64'sh3FFF_FFFF;
    return q;
  endfunction

  function automatic cmd_t clip_cmd(longint v, longint l);
    if (v >= l) return cmd_t'(l);
    if (v <= -l) return (v == 0) ? cmd_t'(0) : cmd_t'(-l);
    return cmd_t'(v);
  endfunction

  // one PD update; advances the held errors, target and waypoint index
  function automatic cmd_word_t pd_law_step(pos_t mx, pos_t my);
    cmd_word_t w;
    int        ex;
    int        ey;
    longint    lim;
    bit        hit;
    ex = int'(tgt_x) - int'(mx);
    ey = int'(tgt_y) - int'(my);
    if (ex > int'(far_dist) || ey > int'(far_dist)) begin
      lim = lim_narrow;
      narrow_hits++;
    end else begin
      lim = lim_wide;
    end
    w.pitch = clip_cmd(scaled_pd(ex, int'(prev_ex)) - longint'(trim), lim);
    w.roll  = clip_cmd(scaled_pd(ey, int'(prev_ey)), lim);
    prev_ex = err_t'(ex);
    prev_ey = err_t'(ey);
    hit = (ex < 0 ? -ex : ex) < int'(thresh) && (ey < 0 ? -ey : ey) < int'(thresh);
    if (hit) begin
      wp_idx = (wp_idx + 1) % NUM_WP;
      advances++;
    end
    tgt_x     = WP_X[wp_idx % 4];
    tgt_y     = WP_Y[wp_idx % 4];
    w.wp      = wp_t'(wp_idx);
    w.arrived = hit;
    return w;
  endfunction

  function automatic pos_t aim_near(pos_t centre, int unsigned span);
    int off;
    off = int'($urandom_range(2 * span)) - int'(span);
    return pos_t'(int'(centre) + off);
  endfunction

  // appends one expected command word at the tail of the queue
  task automatic queue_expected(cmd_word_t w);
    pending_cmds.insert(pending_cmds.size(), w);
  endtask

  task automatic note_mismatch(string what, longint want, longint got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end else if (errors == MAX_REPORTS + 1) begin
      $display("%0t: further mismatches counted but not listed", $time);
    end
  endtask

  task automatic check_cmd();
    cmd_word_t want;
    if (pending_cmds.size() == 0) begin
      note_mismatch("queued words (unexpected command word)", 0, 1);
      return;
    end
    want = pending_cmds.pop_front();
    if (cmd_ch.roll_cmd !== want.roll) note_mismatch("roll_cmd", want.roll, cmd_ch.roll_cmd);
    if (cmd_ch.pitch_cmd !== want.pitch) begin
      note_mismatch("pitch_cmd", want.pitch, cmd_ch.pitch_cmd);
    end
    if (cmd_ch.waypoint_now !== want.wp) begin
      note_mismatch("waypoint_now", want.wp, cmd_ch.waypoint_now);
    end
    if (cmd_ch.arrived !== want.arrived) begin
      note_mismatch("arrived", want.arrived, cmd_ch.arrived);
    end
    cmds_checked++;
  endtask

  // command sink: checks accepted words, then picks next ready
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.ready <= 1'b0;
    end else begin
      if (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) check_cmd();
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        cmd_ch.ready <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
        hold_seen    <= hold_toggle;
        hold_left    <= HOLD_CYCLES;
        cmd_ch.ready <= 1'b0;
      end else begin
        cmd_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_PROP_GAIN:     kp         = val;
      REG_DERIV_GAIN:    kd         = val;
      REG_ARRIVE_THRESH: thresh     = val[14:0];
      REG_FAR_DISTANCE:  far_dist   = val[14:0];
      REG_NARROW_LIMIT:  lim_narrow = val[14:0];
      REG_WIDE_LIMIT:    lim_wide   = val[14:0];
      REG_PITCH_TRIM:    trim       = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [15:0] kp_v, logic [15:0] kd_v, logic [15:0] thr_v,
                               logic [15:0] far_v, logic [15:0] nar_v, logic [15:0] wid_v,
                               logic [15:0] trim_v);
    write_reg(REG_PROP_GAIN, kp_v);
    write_reg(REG_DERIV_GAIN, kd_v);
    write_reg(REG_ARRIVE_THRESH, thr_v);
    write_reg(REG_FAR_DISTANCE, far_v);
    write_reg(REG_NARROW_LIMIT, nar_v);
    write_reg(REG_WIDE_LIMIT, wid_v);
    write_reg(REG_PITCH_TRIM, trim_v);
    settings_used++;
  endtask

  // offers one word with random idle gaps, returns at the accepting edge
  task automatic send_word(pos_t x, pos_t y);
    while ($urandom_range(99) < send_idle_pct) begin
      meas_ch.valid <= 1'b0;
      @(posedge clk);
    end
    meas_ch.valid  <= 1'b1;
    meas_ch.meas_x <= x;
    meas_ch.meas_y <= y;
    @(posedge clk);
    while (meas_ch.ready !== 1'b1) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [15:0] rand_mag(int unsigned hi);
    return {1'($urandom_range(1)), 15'($urandom_range(hi))};
  endfunction

  initial begin : stimulus
    cmd_word_t   got;
    probe_row_t  row;
    pos_t        x;
    pos_t        y;
    int unsigned sel;
    int unsigned span;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    meas_ch.valid  = 1'b0;
    meas_ch.meas_x = '0;
    meas_ch.meas_y = '0;
    cmd_ch.ready   = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (PROBES[i]) begin
      row = PROBES[i];
      send_word(row.x, row.y);
      got = pd_law_step(row.x, row.y);
      if (row.typed) queue_expected({row.roll, row.pitch, row.wp, row.arrived});
      else queue_expected(got);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      meas_ch.valid <= 1'b0;
      do @(posedge clk); while (pending_cmds.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (phase)
        0: begin
          load_settings(RST_PROP_GAIN, RST_DERIV_GAIN, 16'(RST_ARRIVE_THRESH),
                        16'(RST_FAR_DISTANCE), 16'(RST_NARROW_LIMIT), 16'(RST_WIDE_LIMIT),
                        RST_PITCH_TRIM);
          write_reg(REG_SPARE_IDX, 16'hFFFF);
        end
        1: load_settings(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        2: load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
        PRESSURE_PHASE: load_settings(16'd2048, 16'd8192, 16'd64, 16'd256, 16'd0, 16'd32767,
                                      -16'sd500);
        7: load_settings(16'd4096, 16'd1024, 16'd40, 16'd64, 16'd32767, 16'd0, 16'sd0);
        default: load_settings(16'($urandom), 16'($urandom), rand_mag(300), rand_mag(3000),
                               rand_mag(32767), rand_mag(32767), 16'($urandom));
      endcase
      cfg_wr_en <= 1'b0;
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (phase == PRESSURE_PHASE && n == 50) hold_toggle = ~hold_toggle;
        if (phase == PRESSURE_PHASE && n == 150) begin
          // sender pause until the pipeline has drained
          meas_ch.valid <= 1'b0;
          do @(posedge clk); while (pending_cmds.size() != 0);
        end
        sel = $urandom_range(99);
        if (sel < 55) begin
          case ($urandom_range(2))
            0: span = 4;
            1: span = 24;
            default: span = 60;
          endcase
          x = aim_near(tgt_x, span);
          y = aim_near(tgt_y, span);
        end else if (sel < 80) begin
          x = aim_near(tgt_x, 2000);
          y = aim_near(tgt_y, 2000);
        end else begin
          x = pos_t'($urandom);
          y = pos_t'($urandom);
        end
        send_word(x, y);
        queue_expected(pd_law_step(x, y));
      end
    end

    meas_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cmds.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d position words under %0d register settings; %0d command words checked.",
             words_sent, settings_used, cmds_checked);
    $display("Waypoint advances: %0d, narrow-limit updates: %0d, mismatches: %0d.",
             advances, narrow_hits, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### waypoint_pd_position_controller.f
hdl/wpc_pkg.sv
hdl/wpc_if.sv
hdl/wpc_lane.sv
hdl/wpc_merge.sv
hdl/waypoint_pd_position_controller.sv
tb/sv/waypoint_pd_position_controller_test.sv
